// ===== sv/monomial_exponent_unit_top_defines.svh =====
// Assertion macros shared by the monomial exponent unit RTL.
// Depends on nothing; the using module supplies clk_i and rst_ni.
`ifndef MONOMIAL_EXPONENT_UNIT_TOP_DEFINES_SVH
`define MONOMIAL_EXPONENT_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MEU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("monomial exponent unit: check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("monomial exponent unit: check failed");

`endif

// ===== sv/meu_pkg.sv =====
// Package for the monomial exponent unit: sizes, codes and word types.
// Depends on nothing; used by every module of the unit.
`default_nettype none

package meu_pkg;

  localparam int NUM_VARS  = 4;
  localparam int EXP_WIDTH = 16;

  localparam int LANES   = 4;
  localparam int FIELD_W = 16;
  localparam int LANE_W  = EXP_WIDTH;
  localparam int DEG_W   = LANE_W + 2;
  localparam int DEGA_W  = 18;

  // Exponent bits that survive the lane width.
  localparam logic [FIELD_W-1:0] IN_MASK =
    (EXP_WIDTH >= FIELD_W) ? '1 : FIELD_W'((32'd1 << EXP_WIDTH) - 32'd1);

  typedef enum logic [1:0] {
    FN_MUL  = 2'd0,
    FN_QUO  = 2'd1,
    FN_DIV  = 2'd2,
    FN_LESS = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ORD_LEX     = 2'd0,
    ORD_GREVLEX = 2'd1,
    ORD_DEGLEX  = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVF  = 2'd1,
    STAT_NDIV = 2'd2
  } status_e;

  typedef logic [LANES-1:0][LANE_W-1:0] lane_vec_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] exp_a0;
    logic [FIELD_W-1:0] exp_a1;
    logic [FIELD_W-1:0] exp_a2;
    logic [FIELD_W-1:0] exp_a3;
    logic [FIELD_W-1:0] exp_b0;
    logic [FIELD_W-1:0] exp_b1;
    logic [FIELD_W-1:0] exp_b2;
    logic [FIELD_W-1:0] exp_b3;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] res_e0;
    logic [FIELD_W-1:0] res_e1;
    logic [FIELD_W-1:0] res_e2;
    logic [FIELD_W-1:0] res_e3;
    logic               flag;
    logic [1:0]         status;
    logic [DEGA_W-1:0]  degree_a;
  } res_t;

  // Per-lane status from the lane unit.
  typedef struct packed {
    logic [LANE_W-1:0] prod;
    logic              ovf;
    logic [LANE_W-1:0] quot;
    logic              a_gt;
    logic              a_lt;
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== sv/monomial_exponent_unit_top.sv =====
// Top level of the monomial exponent unit: command register, lanes, order
// compare and result register. Depends on meu_pkg, meu_lane, meu_order and the defines header.
`default_nettype none
`include "monomial_exponent_unit_top_defines.svh"

// Monomial exponent unit.
// Command channel: drive a command word on cmd_i and raise start. The word is
// taken at every rising edge with start high and busy low; busy is always low,
// so a new word may follow in every cycle.
// Each command gives one result word on res_o, marked by res_valid_o for
// exactly one cycle. The command register is loaded at the accepting edge,
// and the result register is loaded from it, so res_valid_o is high in
// the cycle after that. Throughput is one word per cycle, set by the
// single pass of lane adders and compares between the two registers.
// Operations: multiply (saturating lane add), quotient (lane subtract or a
// not-divisible status), divides (lane-wise A <= B) and less-than under the
// order held in the mode register. degree_a is always the sum of A's lanes.
// Configuration channel: cfg_data_i is written into the mode register on an
// edge with cfg_valid_i and cfg_ready_o high; cfg_ready_o is always high.
// Write it only while no command is in flight.
// Reset: both valid flags clear and the mode returns to graded reverse lex.
// The receiver cannot stall: each result word is there for one cycle only.
module monomial_exponent_unit_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire meu_pkg::cmd_t cmd_i,
  output meu_pkg::res_t      res_o,
  output logic               res_valid_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i
);

  logic                 cmd_vld_q;
  meu_pkg::cmd_t        cmd_q;
  logic [1:0]           mode_q;
  logic                 res_vld_q;
  meu_pkg::res_t        res_q;
  meu_pkg::res_t        res_d;

  meu_pkg::lane_vec_t   a_vec;
  meu_pkg::lane_vec_t   b_vec;
  meu_pkg::lane_stat_t [meu_pkg::LANES-1:0] stat;
  logic [meu_pkg::DEG_W-1:0] deg_a;
  logic                 less;
  logic                 any_ovf;
  logic                 any_ndiv;
  logic                 any_agt;

  // Never back-pressure: one word passes per cycle.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Command register: load on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
  end

  // Mode register: reset to graded reverse lex.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= meu_pkg::ORD_GREVLEX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Trim each exponent to the lane width.
  always_comb begin
    a_vec[0] = meu_pkg::LANE_W'(cmd_q.exp_a0 & meu_pkg::IN_MASK);
    a_vec[1] = meu_pkg::LANE_W'(cmd_q.exp_a1 & meu_pkg::IN_MASK);
    a_vec[2] = meu_pkg::LANE_W'(cmd_q.exp_a2 & meu_pkg::IN_MASK);
    a_vec[3] = meu_pkg::LANE_W'(cmd_q.exp_a3 & meu_pkg::IN_MASK);
    b_vec[0] = meu_pkg::LANE_W'(cmd_q.exp_b0 & meu_pkg::IN_MASK);
    b_vec[1] = meu_pkg::LANE_W'(cmd_q.exp_b1 & meu_pkg::IN_MASK);
    b_vec[2] = meu_pkg::LANE_W'(cmd_q.exp_b2 & meu_pkg::IN_MASK);
    b_vec[3] = meu_pkg::LANE_W'(cmd_q.exp_b3 & meu_pkg::IN_MASK);
  end

  // Lanes beyond the variable count read as zero and raise nothing.
  for (genvar i = 0; i < meu_pkg::LANES; i++) begin : g_lane
    if (i < meu_pkg::NUM_VARS) begin : g_used
      meu_lane u_lane (
        .a_i    (a_vec[i]),
        .b_i    (b_vec[i]),
        .stat_o (stat[i])
      );
    end else begin : g_unused
      assign stat[i] = '0;
    end
  end

  meu_order u_order (
    .mode_i  (mode_q),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .stat_i  (stat),
    .deg_a_o (deg_a),
    .less_o  (less)
  );

  always_comb begin
    any_ovf  = 1'b0;
    any_ndiv = 1'b0;
    any_agt  = 1'b0;
    for (int i = 0; i < meu_pkg::LANES; i++) begin
      any_ovf  = any_ovf  | stat[i].ovf;
      any_ndiv = any_ndiv | stat[i].a_lt;
      any_agt  = any_agt  | stat[i].a_gt;
    end
  end

  // Assemble the result word.
  always_comb begin
    res_d          = '0;
    res_d.degree_a = meu_pkg::DEGA_W'(deg_a);
    case (cmd_q.func)
      meu_pkg::FN_MUL: begin
        res_d.res_e0 = meu_pkg::FIELD_W'(stat[0].prod);
        res_d.res_e1 = meu_pkg::FIELD_W'(stat[1].prod);
        res_d.res_e2 = meu_pkg::FIELD_W'(stat[2].prod);
        res_d.res_e3 = meu_pkg::FIELD_W'(stat[3].prod);
        res_d.status = any_ovf ? meu_pkg::STAT_OVF : meu_pkg::STAT_OK;
      end
      meu_pkg::FN_QUO: begin
        if (any_ndiv) begin
          res_d.status = meu_pkg::STAT_NDIV;
        end else begin
          res_d.res_e0 = meu_pkg::FIELD_W'(stat[0].quot);
          res_d.res_e1 = meu_pkg::FIELD_W'(stat[1].quot);
          res_d.res_e2 = meu_pkg::FIELD_W'(stat[2].quot);
          res_d.res_e3 = meu_pkg::FIELD_W'(stat[3].quot);
        end
      end
      meu_pkg::FN_DIV: begin
        res_d.flag = !any_agt;
      end
      default: begin
        res_d.flag = less;
      end
    endcase
  end

  // Result register: the strobe follows the command register's valid flag in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

  // A valid word in the command register raises the result strobe from the result register.
  `MEU_ASSERT_NEXT(a_cmd_to_res, cmd_vld_q, res_valid_o)
  // A word taken now is in the command register at the next edge.
  `MEU_ASSERT_NEXT(a_start_loads, start && !busy, cmd_vld_q)
  // A not-divisible quotient carries all-zero exponents and no flag.
  `MEU_ASSERT_NOW(a_ndiv_zero, res_valid_o && res_o.status == meu_pkg::STAT_NDIV,
                  res_o.res_e0 == '0 && res_o.res_e1 == '0 && res_o.res_e2 == '0 &&
                  res_o.res_e3 == '0 && !res_o.flag)
  // An error status never comes with a set flag.
  `MEU_ASSERT_NOW(a_stat_flag, res_valid_o && res_o.status != meu_pkg::STAT_OK,
                  !res_o.flag)
  // A configuration write lands in the mode register.
  `MEU_ASSERT_NEXT(a_cfg_write, cfg_valid_i && cfg_ready_o, mode_q == $past(cfg_data_i))

endmodule

`default_nettype wire

// ===== sv/meu_lane.sv =====
// One exponent lane: saturating add, subtract and magnitude compare.
// Depends on meu_pkg.
`default_nettype none

module meu_lane (
  input  wire logic [meu_pkg::LANE_W-1:0] a_i,
  input  wire logic [meu_pkg::LANE_W-1:0] b_i,
  output meu_pkg::lane_stat_t             stat_o
);

  logic [meu_pkg::LANE_W:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, b_i};

  always_comb begin
    stat_o.ovf  = sum[meu_pkg::LANE_W];
    stat_o.prod = sum[meu_pkg::LANE_W] ? '1 : sum[meu_pkg::LANE_W-1:0];
    stat_o.quot = a_i - b_i;
    stat_o.a_gt = a_i > b_i;
    stat_o.a_lt = a_i < b_i;
  end

endmodule

`default_nettype wire

// ===== sv/meu_order.sv =====
// Degree sums and monomial order compare (lex, grevlex, deglex).
// Depends on meu_pkg; takes lane compares from meu_lane.
`default_nettype none

module meu_order (
  input  wire logic [1:0]                             mode_i,
  input  wire meu_pkg::lane_vec_t                     a_i,
  input  wire meu_pkg::lane_vec_t                     b_i,
  input  wire meu_pkg::lane_stat_t [meu_pkg::LANES-1:0] stat_i,
  output logic [meu_pkg::DEG_W-1:0]                   deg_a_o,
  output logic                                        less_o
);

  logic [meu_pkg::DEG_W-1:0] deg_b;
  logic                      lex_lt;
  logic                      rev_lt;

  always_comb begin
    deg_a_o = '0;
    deg_b   = '0;
    for (int i = 0; i < meu_pkg::NUM_VARS; i++) begin
      deg_a_o = deg_a_o + meu_pkg::DEG_W'(a_i[i]);
      deg_b   = deg_b + meu_pkg::DEG_W'(b_i[i]);
    end
  end

  // Lex: first differing lane decides; revlex: last differing lane, larger is smaller.
  always_comb begin
    lex_lt = 1'b0;
    rev_lt = 1'b0;
    for (int i = meu_pkg::NUM_VARS - 1; i >= 0; i--) begin
      if (stat_i[i].a_gt || stat_i[i].a_lt) begin
        lex_lt = stat_i[i].a_lt;
      end
    end
    for (int i = 0; i < meu_pkg::NUM_VARS; i++) begin
      if (stat_i[i].a_gt || stat_i[i].a_lt) begin
        rev_lt = stat_i[i].a_gt;
      end
    end
  end

  always_comb begin
    case (mode_i)
      meu_pkg::ORD_LEX:    less_o = lex_lt;
      meu_pkg::ORD_DEGLEX: less_o = (deg_a_o != deg_b) ? (deg_a_o < deg_b) : lex_lt;
      default:             less_o = (deg_a_o != deg_b) ? (deg_a_o < deg_b) : rev_lt;
    endcase
  end

endmodule

`default_nettype wire
